### rtl/vdphp_pkg.sv
// ----------------------------------------------------------------------------
// vdphp_pkg
// Opcodes, field widths and the result layout shared by the host port logic.
// ----------------------------------------------------------------------------
package vdphp_pkg;

    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [BYTE_W-1:0]   t_byte;

    // Host bus operations carried in the input tuser field.
    localparam t_opcode OP_DATA_WR   = 3'd0;
    localparam t_opcode OP_DATA_RD   = 3'd1;
    localparam t_opcode OP_CTRL_WR   = 3'd2;
    localparam t_opcode OP_STATUS_RD = 3'd3;
    localparam t_opcode OP_FRAME     = 3'd4;

    // Register file geometry and the interrupt enable location.
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = 3;
    localparam int INT_EN_REG  = 1;
    localparam int INT_EN_BIT  = 5;

    // Control byte decode: bit 7 selects a register write, bits 5:0 hold the
    // upper part of a VRAM address.
    localparam int CTRL_REG_BIT = 7;
    localparam int PTR_HI_W     = 6;

    // One result transfer, highest field first.
    typedef struct packed {
        logic  second_byte_expected;
        logic  interrupt_out;
        t_byte read_data;
    } t_result;

    localparam int RESULT_W   = $bits(t_result);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### rtl/vdp_host_port_interface.sv
// ----------------------------------------------------------------------------
// vdp_host_port_interface
// Host side of a video display processor: control, data and status ports.
// ----------------------------------------------------------------------------
// Usage: each input transfer is one host bus operation. i_s_tuser carries the
// opcode (data write, data read, control write, status read, frame tick) and
// i_s_tdata the byte for the data or control port. Every operation produces
// exactly one output transfer on the master side, in order, holding the read
// byte (VRAM byte or status byte, else zero), the interrupt line and the
// control pair latch as they stand after the operation.
// Timing and throughput: a data read passes through the synchronous VRAM
// read register and then the output register, and no new operation is taken
// until its result is loaded. Every other operation is answered in the output
// register in the cycle after its transfer, so a stream without data reads
// runs at one operation per cycle while the receiver keeps i_m_tready high.
// A new operation is taken while no VRAM read is pending and the output
// register is empty or is being drained in the same cycle; when the receiver
// stalls, the result is held and o_s_tready drops until it is taken.
// Reset clears the VRAM pointer, pair latch, first control byte, register
// file and vsync flag. VRAM contents are not cleared; an unwritten entry
// reads as an arbitrary value.
// ----------------------------------------------------------------------------
module vdp_host_port_interface
    import vdphp_pkg::*;
#(
    parameter int VRAM_ADDR_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side: host operations.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] data_byte
    input  logic [OPCODE_W-1:0]   i_s_tuser,   // [2:0] opcode
    // Master side: one result per operation.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [7:0] read_data,
                                               // [8] interrupt_out,
                                               // [9] second_byte_expected,
                                               // [15:10] zero
);

    localparam int VRAM_DEPTH = 1 << VRAM_ADDR_BITS;

    // Sequencer: idle, or waiting for VRAM read data.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    typedef logic [VRAM_ADDR_BITS-1:0] t_addr;

    // Video memory, read and written synchronously at the VRAM pointer.
    t_byte r_vram [VRAM_DEPTH];
    t_byte r_vram_q;

    logic    r_state,     n_state;
    t_addr   r_ptr,       n_ptr;
    logic    r_pair,      n_pair;
    t_byte   r_first,     n_first;
    logic    r_vsync,     n_vsync;
    t_byte   r_regs [REG_COUNT];
    logic    r_out_valid, n_out_valid;
    t_result r_out,       n_out;

    logic                 w_accept;
    t_opcode              w_op;
    t_byte                w_byte;
    logic                 w_reg_we;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_int_en;
    t_byte                w_rdata;
    logic [13:0]          w_ptr_load;

    assign w_op      = i_s_tuser;
    assign w_byte    = i_s_tdata;
    assign w_reg_idx = w_byte[REG_IDX_W-1:0];

    // Take a new operation only when idle and the output register is free
    // or being drained in this cycle.
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, r_out};

    // The control pair forms a 14-bit address, then fits the VRAM size.
    assign w_ptr_load = {w_byte[PTR_HI_W-1:0], r_first};

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pair      = r_pair;
        n_first     = r_first;
        n_vsync     = r_vsync;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_reg_we    = 1'b0;
        w_rdata     = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            case (w_op)
                OP_DATA_WR: begin
                    n_ptr = r_ptr + 1'b1;
                end
                OP_DATA_RD: begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = ST_READ;
                end
                OP_CTRL_WR: begin
                    if (!r_pair) begin
                        n_first = w_byte;
                        n_pair  = 1'b1;
                    end else begin
                        n_pair = 1'b0;
                        if (w_byte[CTRL_REG_BIT]) begin
                            w_reg_we = 1'b1;
                        end else begin
                            n_ptr = VRAM_ADDR_BITS'(w_ptr_load);
                        end
                    end
                end
                OP_STATUS_RD: begin
                    w_rdata = {r_vsync, 7'b0};
                    n_vsync = 1'b0;
                    n_pair  = 1'b0;
                end
                OP_FRAME: begin
                    n_vsync = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Interrupt enable as it stands after this operation.
        if (w_reg_we && (w_reg_idx == REG_IDX_W'(INT_EN_REG))) begin
            w_int_en = r_first[INT_EN_BIT];
        end else begin
            w_int_en = r_regs[INT_EN_REG][INT_EN_BIT];
        end

        if (w_accept && (w_op != OP_DATA_RD)) begin
            n_out_valid                = 1'b1;
            n_out.read_data            = w_rdata;
            n_out.interrupt_out        = n_vsync & w_int_en;
            n_out.second_byte_expected = n_pair;
        end else if (r_state == ST_READ) begin
            // A data read changes neither the flags nor the registers.
            n_state                    = ST_IDLE;
            n_out_valid                = 1'b1;
            n_out.read_data            = r_vram_q;
            n_out.interrupt_out        = r_vsync & r_regs[INT_EN_REG][INT_EN_BIT];
            n_out.second_byte_expected = r_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_pair      <= 1'b0;
            r_first     <= '0;
            r_vsync     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_pair      <= n_pair;
            r_first     <= n_first;
            r_vsync     <= n_vsync;
            r_out_valid <= n_out_valid;
            if (w_reg_we) begin
                r_regs[w_reg_idx] <= r_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // VRAM port: write or read at the current pointer.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_op == OP_DATA_WR)) begin
            r_vram[r_ptr] <= w_byte;
        end
        if (w_accept && (w_op == OP_DATA_RD)) begin
            r_vram_q <= r_vram[r_ptr];
        end
    end

`ifndef SYNTHESIS
    // While VRAM read data is pending the output register must be free.
    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("output register busy during VRAM read");

    // A data read always goes through the read wait state.
    a_read_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_DATA_RD)) |=> (r_state == ST_READ) && !o_s_tready)
        else $error("data read did not wait for VRAM");

    // Data port accesses advance the pointer by one with wrap.
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((w_op == OP_DATA_WR) || (w_op == OP_DATA_RD)))
        |=> (r_ptr == t_addr'($past(r_ptr) + 1'b1)))
        else $error("VRAM pointer did not advance");

    // A status read answers at once and clears the pair latch and vsync.
    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_STATUS_RD))
        |=> o_m_tvalid && !r_pair && !r_vsync && !r_out.second_byte_expected)
        else $error("status read did not clear flags");
`endif

endmodule
